/* rtl/ffbp_pkg.sv */
package ffbp_pkg;

   localparam int SIZE_W = 16;
   localparam int IDX_W  = 6;
   localparam int USED_W = 7;

   localparam logic [SIZE_W-1:0] CAP_RESET = 16'hFFFF;

   typedef enum logic [1:0] {
      ST_PLACED   = 2'd0,
      ST_OVERSIZE = 2'd1,
      ST_NO_BIN   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SEARCH,
      FSM_FINISH
   } fsm_type;

   // what a cell reports in the cycle it holds the search token
   typedef struct packed {
      logic hit;
      logic opened;
   } cell_event_type;

endpackage

/* rtl/ffbp_if.sv */
interface ffbp_req_if;
   import ffbp_pkg::*;

   logic              valid;
   logic              ready;
   logic [SIZE_W-1:0] item_size;
   logic              new_run;

   modport source (output valid, output item_size, output new_run, input ready);
   modport sink   (input valid, input item_size, input new_run, output ready);
endinterface

interface ffbp_rsp_if;
   import ffbp_pkg::*;

   logic              valid;
   logic              ready;
   logic [IDX_W-1:0]  bin_index;
   logic [USED_W-1:0] bins_used;
   logic [1:0]        status;

   modport source (output valid, output bin_index, output bins_used, output status,
                   input ready);
   modport sink   (input valid, input bin_index, input bins_used, input status,
                   output ready);
endinterface

/* rtl/first_fit_bin_packer_unit.sv */
// channel   direction  handshake      payload
// req_ch    in         valid/ready    item_size[15:0], new_run
// rsp_ch    out        valid/ready    bin_index[5:0], bins_used[6:0], status[1:0]
// csr       in         csr_wr_en      csr_wr_data[15:0] -> bin_capacity
//
// one request is searched at a time; a search token walks the bin cells one per cycle
// an item placed in bin k goes through accept, a token step at each of cells 0 to k, then result load
// no fit with all bins open walks the token past every cell, an oversized item skips the search
// reset clears the bin count, the token and the output valid, and sets the capacity to 65535
// cell contents are not cleared, only open cells are read
// a stalled result waits in the output register while the next request is taken
module first_fit_bin_packer_unit #(
   parameter int MAX_BINS = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [ffbp_pkg::SIZE_W-1:0] csr_wr_data,
   ffbp_req_if.sink                    req_ch,
   ffbp_rsp_if.source                  rsp_ch
);
   import ffbp_pkg::*;

   localparam int CW = $clog2(MAX_BINS + 1);

   // token chain: tok[i] feeds cell i, the last tap means nothing fit
   logic [MAX_BINS:0]  tok;
   cell_event_type     cell_evt [MAX_BINS];
   cell_event_type     chain_evt;
   logic               start;
   logic [SIZE_W-1:0]  size;
   logic [SIZE_W-1:0]  cap;
   logic [CW-1:0]      count;

   assign tok[0] = start;

   // only the cell holding the token reports, so an or merges the chain
   always_comb begin
      chain_evt = '0;
      for (int i = 0; i < MAX_BINS; i++) begin
         chain_evt.hit    = chain_evt.hit | cell_evt[i].hit;
         chain_evt.opened = chain_evt.opened | cell_evt[i].opened;
      end
   end

   // sequencer, capacity register and output register
   ffbp_ctrl #(
      .MAX_BINS (MAX_BINS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .chain_evt   (chain_evt),
      .tail_tok    (tok[MAX_BINS]),
      .start       (start),
      .size        (size),
      .cap         (cap),
      .count       (count)
   );

   // one cell per bin, each keeping that bin's remaining room
   for (genvar g = 0; g < MAX_BINS; g++) begin : g_cell
      ffbp_cell #(
         .MAX_BINS (MAX_BINS),
         .INDEX    (g)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .prev_tok (tok[g]),
         .count    (count),
         .size     (size),
         .cap      (cap),
         .tok_out  (tok[g+1]),
         .cell_evt (cell_evt[g])
      );
   end

endmodule

/* rtl/ffbp_cell.sv */
module ffbp_cell #(
   parameter int MAX_BINS = 64,
   parameter int INDEX    = 0,
   localparam int CW      = $clog2(MAX_BINS + 1)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           prev_tok,
   input  logic [CW-1:0]                  count,
   input  logic [ffbp_pkg::SIZE_W-1:0]    size,
   input  logic [ffbp_pkg::SIZE_W-1:0]    cap,
   output logic                           tok_out,
   output ffbp_pkg::cell_event_type       cell_evt
);
   import ffbp_pkg::*;

   logic              tok_ff, tok_in;
   logic [SIZE_W-1:0] rem_ff, rem_in;
   logic              is_open;
   logic              fits;
   logic              hit;

   assign tok_in  = prev_tok;
   assign is_open = (CW'(INDEX) < count);
   assign fits    = (rem_ff >= size);
   // a closed cell seen by the token is always the next bin to open
   assign hit     = tok_ff & (fits | ~is_open);
   assign tok_out = tok_ff & ~hit;

   assign cell_evt.hit    = hit;
   assign cell_evt.opened = hit & ~is_open;

   always_comb begin
      rem_in = rem_ff;
      if (hit) begin
         if (is_open) begin
            rem_in = rem_ff - size;
         end else begin
            rem_in = cap - size;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= 1'b0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
   end

endmodule

/* rtl/ffbp_ctrl.sv */
module ffbp_ctrl #(
   parameter int MAX_BINS = 64,
   localparam int CW      = $clog2(MAX_BINS + 1),
   localparam int IW      = $clog2(MAX_BINS)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [ffbp_pkg::SIZE_W-1:0] csr_wr_data,
   ffbp_req_if.sink                    req,
   ffbp_rsp_if.source                  rsp,
   input  ffbp_pkg::cell_event_type    chain_evt,
   input  logic                        tail_tok,
   output logic                        start,
   output logic [ffbp_pkg::SIZE_W-1:0] size,
   output logic [ffbp_pkg::SIZE_W-1:0] cap,
   output logic [CW-1:0]               count
);
   import ffbp_pkg::*;

   fsm_type           state_ff, state_in;
   logic [IW-1:0]     pos_ff, pos_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [SIZE_W-1:0] cap_ff, cap_in;
   logic [IW-1:0]     res_index_ff, res_index_in;
   status_type        res_status_ff, res_status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]  rsp_index_ff, rsp_index_in;
   logic [USED_W-1:0] rsp_used_ff, rsp_used_in;
   status_type        rsp_status_ff, rsp_status_in;

   logic                   accept;
   logic                   load;
   logic [CW+USED_W-1:0]   used_wide;
   logic [IW+IDX_W-1:0]    index_wide;

   assign req.ready     = (state_ff == FSM_IDLE);
   assign accept        = req.valid & req.ready;
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.bin_index = rsp_index_ff;
   assign rsp.bins_used = rsp_used_ff;
   assign rsp.status    = rsp_status_ff;
   assign size          = size_ff;
   assign cap           = cap_ff;
   assign count         = count_ff;
   assign used_wide     = {{USED_W{1'b0}}, count_ff};
   assign index_wide    = {{IDX_W{1'b0}}, res_index_ff};
   assign cap_in        = csr_wr_en ? csr_wr_data : cap_ff;

   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      count_in      = count_ff;
      size_in       = size_ff;
      res_index_in  = res_index_ff;
      res_status_in = res_status_ff;
      start         = 1'b0;
      load          = 1'b0;
      unique case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               size_in = req.item_size;
               if (req.new_run) begin
                  count_in = '0;
               end
               if (req.item_size > cap_ff) begin
                  res_index_in  = '0;
                  res_status_in = ST_OVERSIZE;
                  state_in      = FSM_FINISH;
               end else begin
                  start    = 1'b1;
                  pos_in   = '0;
                  state_in = FSM_SEARCH;
               end
            end
         end
         FSM_SEARCH: begin
            priority if (chain_evt.hit) begin
               res_index_in  = pos_ff;
               res_status_in = ST_PLACED;
               if (chain_evt.opened) begin
                  count_in = count_ff + 1'b1;
               end
               state_in = FSM_FINISH;
            end else if (tail_tok) begin
               res_index_in  = '0;
               res_status_in = ST_NO_BIN;
               state_in      = FSM_FINISH;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
         FSM_FINISH: begin
            if (!rsp_valid_ff || rsp.ready) begin
               load     = 1'b1;
               state_in = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_used_in   = rsp_used_ff;
      rsp_status_in = rsp_status_ff;
      if (load) begin
         rsp_valid_in  = 1'b1;
         rsp_index_in  = index_wide[IDX_W-1:0];
         rsp_used_in   = used_wide[USED_W-1:0];
         rsp_status_in = res_status_ff;
      end else if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      size_ff       <= size_in;
      res_index_ff  <= res_index_in;
      res_status_ff <= res_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_used_ff   <= rsp_used_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;
   import ffbp_pkg::*;

   localparam int MAX_BINS = 64;
   localparam int RING_DEPTH = 16;

   // what one placement should look like on the result channel
   typedef struct packed {
      logic [IDX_W-1:0]  bin_index;
      logic [USED_W-1:0] bins_used;
      status_type        status;
   } placement_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_wr_en;
   logic [SIZE_W-1:0] csr_wr_data;

   ffbp_req_if req_ch ();
   ffbp_rsp_if rsp_ch ();

   first_fit_bin_packer_unit #(
      .MAX_BINS (MAX_BINS)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch)
   );

   // 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // packer state as the bench sees it
   logic [SIZE_W-1:0] bin_room [MAX_BINS];
   int                bins_open;
   logic [SIZE_W-1:0] bin_cap;

   // placements predicted at request acceptance, oldest first
   placement_type expect_ring [RING_DEPTH];
   int            expect_wr;
   int            expect_rd;
   int            mismatches;

   // knobs for idling on each side
   bit req_gap_on;
   bit rsp_stall_on;
   int stall_left;

   // first-fit placement of one object, updates the bench copy of the bins
   function automatic placement_type place_object(logic [SIZE_W-1:0] obj_size, logic fresh);
      placement_type res;
      bit            found;
      res.bin_index = '0;
      res.status    = ST_PLACED;
      found         = 1'b0;
      // a new run closes every bin before the object goes in
      if (fresh)
         bins_open = 0;
      // oversize check comes first, even if an older bin still has room
      if (obj_size > bin_cap) begin
         res.status = ST_OVERSIZE;
      end else begin
         // lowest-numbered open bin with enough room, inclusive test
         for (int k = 0; k < bins_open; k++) begin
            if (!found && bin_room[k] >= obj_size) begin
               bin_room[k]   = bin_room[k] - obj_size;
               res.bin_index = IDX_W'(k);
               found         = 1'b1;
            end
         end
         if (!found) begin
            if (bins_open < MAX_BINS) begin
               // open a fresh bin at the current capacity
               res.bin_index       = IDX_W'(bins_open);
               bin_room[bins_open] = bin_cap - obj_size;
               bins_open++;
            end else begin
               res.status = ST_NO_BIN;
            end
         end
      end
      res.bins_used = USED_W'(bins_open);
      return res;
   endfunction

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 92)
         return int'($urandom_range(1, 3));
      return int'($urandom_range(8, 40));
   endfunction

   // object sizes shaped around the current capacity
   function automatic logic [SIZE_W-1:0] pick_size();
      int unsigned c;
      int unsigned r;
      c = {16'd0, bin_cap};
      r = $urandom_range(0, 99);
      if (r < 5)
         return '0;
      // exact fill
      if (r < 12)
         return SIZE_W'(c);
      // oversized, only possible below the top capacity
      if (r < 18)
         return (c < 65535) ? SIZE_W'($urandom_range(c + 1, 65535))
                            : SIZE_W'($urandom_range(0, c));
      // more than half a bin, forces new bins quickly
      if (r < 45)
         return SIZE_W'($urandom_range(c / 2 + 1, c));
      // small objects that pack into earlier bins
      if (r < 75)
         return SIZE_W'($urandom_range(0, c / 8));
      return SIZE_W'($urandom_range(0, c));
   endfunction

   function automatic logic [SIZE_W-1:0] pick_capacity();
      case ($urandom_range(0, 4))
         0: return 16'd1;
         1: return CAP_RESET;
         2: return SIZE_W'($urandom_range(2, 64));
         3: return SIZE_W'($urandom_range(100, 5000));
         default: return SIZE_W'($urandom_range(1, 65535));
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 100)
         $display("[%0t] mismatch: %s", $time, msg);
   endtask

   // one request transaction; returns at the accepting edge
   task automatic send_item(input logic [SIZE_W-1:0] obj_size, input logic fresh);
      int gap;
      gap = req_gap_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.item_size <= obj_size;
      req_ch.new_run   <= fresh;
      do @(posedge clock); while (!req_ch.ready);
      expect_ring[expect_wr % RING_DEPTH] = place_object(obj_size, fresh);
      expect_wr++;
   endtask

   // hold off the sender until every predicted placement has come back
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (expect_wr != expect_rd)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // capacity is only written with nothing in flight
   task automatic write_capacity(input logic [SIZE_W-1:0] value);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      bin_cap = value;
   endtask

   // result side: random backpressure with stall-free stretches
   always @(posedge clock) begin
      if (reset || !rsp_stall_on) begin
         rsp_ch.ready <= 1'b1;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ch.ready <= 1'b1;
         stall_left = pick_gap();
      end
   end

   // every result transaction against the oldest prediction
   always @(posedge clock) begin : check_results
      placement_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expect_wr == expect_rd) begin
            report_mismatch($sformatf("result with nothing expected: bin %0d used %0d status %0d",
                                      rsp_ch.bin_index, rsp_ch.bins_used,
                                      rsp_ch.status));
         end else begin
            want = expect_ring[expect_rd % RING_DEPTH];
            expect_rd++;
            if (rsp_ch.bin_index !== want.bin_index)
               report_mismatch($sformatf("bin_index %0d, expected %0d",
                                         rsp_ch.bin_index, want.bin_index));
            if (rsp_ch.bins_used !== want.bins_used)
               report_mismatch($sformatf("bins_used %0d, expected %0d",
                                         rsp_ch.bins_used, want.bins_used));
            if (rsp_ch.status !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_ch.status, want.status));
         end
      end
   end

   // reset capacity, inclusive fit and zero-size objects
   task automatic test_default_capacity();
      send_item(16'd65535, 1'b1);
      send_item(16'd0, 1'b0);
      send_item(16'd1, 1'b0);
      send_item(16'd65534, 1'b0);
      send_item(16'd0, 1'b0);
      send_item(16'd1, 1'b0);
   endtask

   // capacity lowered mid-run: oversize wins even where an old bin has room
   task automatic test_oversize_rule();
      write_capacity(16'd100);
      send_item(16'd200, 1'b0);
      send_item(16'd50, 1'b0);
      send_item(16'd101, 1'b1);
      send_item(16'd100, 1'b0);
      send_item(16'd0, 1'b0);
   endtask

   // capacity of one, capacity of zero, and the largest again
   task automatic test_capacity_extremes();
      write_capacity(16'd1);
      send_item(16'd1, 1'b1);
      send_item(16'd1, 1'b0);
      send_item(16'd2, 1'b0);
      send_item(16'd0, 1'b0);
      write_capacity(16'd0);
      send_item(16'd0, 1'b1);
      send_item(16'd1, 1'b0);
      send_item(16'd0, 1'b0);
      send_item(16'd0, 1'b1);
      write_capacity(CAP_RESET);
      send_item(16'd32768, 1'b1);
      send_item(16'd32767, 1'b0);
      send_item(16'd32768, 1'b0);
   endtask

   // open every bin, then ask for more
   task automatic test_bin_exhaustion();
      logic [SIZE_W-1:0] caps [3];
      caps[0] = 16'd1;
      caps[1] = CAP_RESET;
      caps[2] = SIZE_W'($urandom_range(2, 65535));
      foreach (caps[n]) begin
         write_capacity(caps[n]);
         for (int k = 0; k < MAX_BINS + 4; k++)
            send_item(SIZE_W'($urandom_range(bin_cap / 2 + 1, bin_cap)), k == 0);
         // a zero-size object still fits the first bin
         send_item(16'd0, 1'b0);
         send_item(pick_size(), 1'b0);
      end
   endtask

   // runs of random objects across random capacities
   task automatic test_random_runs(input int budget);
      int sent;
      int run_len;
      sent = 0;
      while (sent < budget) begin
         // some phases run with no idling at all
         req_gap_on   = $urandom_range(0, 3) != 0;
         rsp_stall_on = $urandom_range(0, 3) != 0;
         write_capacity(pick_capacity());
         repeat ($urandom_range(1, 4)) begin
            run_len = $urandom_range(1, 90);
            for (int k = 0; k < run_len; k++) begin
               // first object of a run usually starts fresh, otherwise the
               // old bins carry over under the new capacity
               send_item(pick_size(),
                         (k == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 199) == 0));
               sent++;
               if ($urandom_range(0, 127) == 0)
                  wait_idle();
            end
         end
      end
   endtask

   initial begin
      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      req_ch.valid     = 1'b0;
      req_ch.item_size = '0;
      req_ch.new_run   = 1'b0;
      rsp_ch.ready     = 1'b0;
      foreach (bin_room[k])
         bin_room[k] = '0;
      bins_open    = 0;
      bin_cap      = CAP_RESET;
      expect_wr    = 0;
      expect_rd    = 0;
      mismatches   = 0;
      req_gap_on   = 1'b1;
      rsp_stall_on = 1'b1;
      stall_left   = 0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_default_capacity();
      test_oversize_rule();
      test_capacity_extremes();
      test_bin_exhaustion();
      test_random_runs(1660);

      // drain and allow a full search through all bins for stray results
      wait_idle();
      repeat (MAX_BINS + 8) @(posedge clock);
      if (mismatches == 0 && expect_wr == expect_rd)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // hard stop far beyond the slowest legal run
   initial begin
      #30000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

/* sim.f */
rtl/ffbp_pkg.sv
rtl/ffbp_if.sv
rtl/ffbp_cell.sv
rtl/ffbp_ctrl.sv
rtl/first_fit_bin_packer_unit.sv
bench/tb.sv
